@@ hw/rtl/szoc_pkg.sv @@
// ----------------------------------------------------------------------------
// szoc_pkg
// Shared widths, reset values, opcodes and register indexes of the
// stillness zero-offset calibrator.
// ----------------------------------------------------------------------------
package szoc_pkg;

  localparam int FieldW        = 16;
  localparam int TickW         = 32;
  localparam int IntervalW     = 16;
  localparam int LimitW        = 24;
  localparam int CfgDataW      = 24;
  localparam int CfgIdxW       = 2;

  localparam int WindowDef     = 128;
  localparam int SampleBitsDef = 16;

  localparam logic [IntervalW-1:0] IntervalRst = IntervalW'(50);
  localparam logic [LimitW-1:0]    LimitRst    = LimitW'(164);

  typedef enum logic [0:0] {
    OP_SAMPLE  = 1'b0,
    OP_RESTART = 1'b1
  } opcode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INTERVAL  = 2'd0,
    REG_PITCH_LIM = 2'd1,
    REG_ROLL_LIM  = 2'd2
  } reg_idx_t;

endpackage

@@ hw/rtl/szoc_ifs.sv @@
// ----------------------------------------------------------------------------
// szoc_ifs
// Valid/ready stream interfaces for sample beats and result beats.
// ----------------------------------------------------------------------------
interface szoc_in_if;
  import szoc_pkg::*;

  logic                     valid;
  logic                     ready;
  opcode_t                  opcode;
  logic signed [FieldW-1:0] pitch_sample;
  logic signed [FieldW-1:0] roll_sample;
  logic [TickW-1:0]         now_tick;

  modport source (output valid, output opcode, output pitch_sample,
                  output roll_sample, output now_tick, input ready);
  modport sink   (input valid, input opcode, input pitch_sample,
                  input roll_sample, input now_tick, output ready);
endinterface

interface szoc_out_if;
  import szoc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     sample_taken;
  logic                     is_calibrated;
  logic signed [FieldW-1:0] pitch_bias;
  logic signed [FieldW-1:0] roll_bias;

  modport source (output valid, output sample_taken, output is_calibrated,
                  output pitch_bias, output roll_bias, input ready);
  modport sink   (input valid, input sample_taken, input is_calibrated,
                  input pitch_bias, input roll_bias, output ready);
endinterface

@@ hw/rtl/szoc_ring.sv @@
// ----------------------------------------------------------------------------
// szoc_ring
// Sample window memory for both channels: one write port, one registered
// read port.
// ----------------------------------------------------------------------------
module szoc_ring #(
  parameter  int WINDOW      = 128,
  parameter  int SAMPLE_BITS = 16,
  localparam int L           = $clog2(WINDOW)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [L-1:0]           wr_addr,
  input  logic [SAMPLE_BITS-1:0] wr_pitch,
  input  logic [SAMPLE_BITS-1:0] wr_roll,
  input  logic [L-1:0]           rd_addr,
  output logic [SAMPLE_BITS-1:0] rd_pitch_r,
  output logic [SAMPLE_BITS-1:0] rd_roll_r
);

  logic [2*SAMPLE_BITS-1:0] mem [WINDOW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_pitch, wr_roll};
    end
  end

  always_ff @(posedge clk) begin
    {rd_pitch_r, rd_roll_r} <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/szoc_still.sv @@
// ----------------------------------------------------------------------------
// szoc_still
// Stillness test of one channel: WINDOW*sumsq - sum^2 < limit*WINDOW^2.
// ----------------------------------------------------------------------------
module szoc_still #(
  parameter  int WINDOW      = 128,
  parameter  int SAMPLE_BITS = 16,
  localparam int L           = $clog2(WINDOW),
  localparam int SumW        = SAMPLE_BITS + L,
  localparam int SqW         = 2 * SAMPLE_BITS - 1 + L
) (
  input  logic signed [SumW-1:0]           sum,
  input  logic [SqW-1:0]                   sq_sum,
  input  logic [szoc_pkg::LimitW-1:0]      limit,
  output logic                             still
);
  import szoc_pkg::*;

  localparam int ProdW = 2 * SumW;
  localparam int BndW  = LimitW + 2 * L;
  localparam int CmpW  = (ProdW > BndW) ? ProdW : BndW;

  logic [SumW-1:0]  mag;
  logic [ProdW-1:0] mag_sq;
  logic [CmpW-1:0]  scaled;
  logic [CmpW-1:0]  diff;
  logic [CmpW-1:0]  bound;

  assign mag    = sum[SumW-1] ? (~$unsigned(sum) + 1'b1) : $unsigned(sum);
  assign mag_sq = mag * mag;
  assign scaled = CmpW'(sq_sum) << L;
  assign diff   = scaled - CmpW'(mag_sq);
  assign bound  = CmpW'(limit) << (2 * L);
  assign still  = diff < bound;

endmodule

@@ hw/rtl/stillness_zero_offset_calibrator.sv @@
// ----------------------------------------------------------------------------
// stillness_zero_offset_calibrator
// Zero-offset calibrator for pitch and roll: windowed mean once both
// channels show low variance.
// ----------------------------------------------------------------------------
// Each accepted beat gives exactly one result beat, passing from the input
// register through the update stage and then the stillness stage into the
// result register. A new beat is accepted every cycle while the result side
// is not stalled, except that a sample taken with the window full, or filling
// it, holds the next beat in the input register while the variance test reads
// the updated running sums; once the window is full a taken sample therefore
// never overlaps the next beat in the update stage. The oldest window entry
// is prefetched from the ring memory through its registered read port, so no
// memory access stands in the update loop. Window entries are undefined until
// written and need no clearing after reset; WINDOW must be a power of two.
// ----------------------------------------------------------------------------
module stillness_zero_offset_calibrator #(
  parameter int WINDOW      = szoc_pkg::WindowDef,
  parameter int SAMPLE_BITS = szoc_pkg::SampleBitsDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  szoc_in_if.sink                        in_ch,
  szoc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [szoc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [szoc_pkg::CfgDataW-1:0]  cfg_wdata
);
  import szoc_pkg::*;

  localparam int L     = $clog2(WINDOW);
  localparam int SB    = SAMPLE_BITS;
  localparam int SumW  = SB + L;
  localparam int SqW   = 2 * SB - 1 + L;
  localparam int FillW = L + 1;

  // configuration
  logic [IntervalW-1:0] interval_r;
  logic [LimitW-1:0]    plim_r;
  logic [LimitW-1:0]    rlim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= IntervalRst;
      plim_r     <= LimitRst;
      rlim_r     <= LimitRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTERVAL:  interval_r <= IntervalW'(cfg_wdata);
        REG_PITCH_LIM: plim_r     <= LimitW'(cfg_wdata);
        REG_ROLL_LIM:  rlim_r     <= LimitW'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // input register
  logic              a_valid_r;
  opcode_t           a_op_r;
  logic [FieldW-1:0] a_pitch_r;
  logic [FieldW-1:0] a_roll_r;
  logic [TickW-1:0]  a_tick_r;

  // update stage
  logic                   c_valid_r;
  logic                   c_taken_r;
  logic                   c_chk_r;
  logic                   c_adv;
  logic                   b_fire;
  logic                   in_fire;

  // calibration state
  logic [L-1:0]           wpos_r;
  logic [L-1:0]           wpos_nxt;
  logic [FillW-1:0]       fill_r;
  logic signed [SumW-1:0] psum_r;
  logic signed [SumW-1:0] rsum_r;
  logic [SqW-1:0]         psq_r;
  logic [SqW-1:0]         rsq_r;
  logic [TickW-1:0]       last_tick_r;
  logic                   cal_r;
  logic [SB-1:0]          pzero_r;
  logic [SB-1:0]          rzero_r;

  // result register
  logic              out_valid_r;
  logic              out_taken_r;
  logic              out_cal_r;
  logic [FieldW-1:0] out_pitch_r;
  logic [FieldW-1:0] out_roll_r;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !a_valid_r || b_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (b_fire) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_op_r    <= in_ch.opcode;
      a_pitch_r <= $unsigned(in_ch.pitch_sample);
      a_roll_r  <= $unsigned(in_ch.roll_sample);
      a_tick_r  <= in_ch.now_tick;
    end
  end

  // update stage logic
  logic                   is_restart;
  logic                   tick_ok;
  logic                   take;
  logic                   full;
  logic                   chk;
  logic [TickW-1:0]       tick_diff;
  logic signed [SB-1:0]   p_new;
  logic signed [SB-1:0]   r_new;
  logic [SB-1:0]          p_old_raw;
  logic [SB-1:0]          r_old_raw;
  logic signed [SB-1:0]   p_old;
  logic signed [SB-1:0]   r_old;
  logic signed [2*SB-1:0] p_sq;
  logic signed [2*SB-1:0] r_sq;
  logic signed [2*SB-1:0] p_old_sq;
  logic signed [2*SB-1:0] r_old_sq;
  logic signed [SumW-1:0] p_sub;
  logic signed [SumW-1:0] r_sub;
  logic [SqW-1:0]         p_sq_sub;
  logic [SqW-1:0]         r_sq_sub;
  logic signed [SumW-1:0] psum_nxt;
  logic signed [SumW-1:0] rsum_nxt;
  logic [SqW-1:0]         psq_nxt;
  logic [SqW-1:0]         rsq_nxt;

  assign b_fire = a_valid_r && (!c_valid_r || (!c_chk_r && c_adv));

  assign is_restart = (a_op_r == OP_RESTART);
  assign tick_diff  = a_tick_r - last_tick_r;
  assign tick_ok    = tick_diff >= TickW'(interval_r);
  assign take       = !is_restart && !cal_r && tick_ok;
  assign full       = (fill_r == FillW'(WINDOW));
  assign chk        = take && (full || (fill_r == FillW'(WINDOW - 1)));

  assign p_new = SB'(a_pitch_r);
  assign r_new = SB'(a_roll_r);
  assign p_old = p_old_raw;
  assign r_old = r_old_raw;

  assign p_sq     = p_new * p_new;
  assign r_sq     = r_new * r_new;
  assign p_old_sq = p_old * p_old;
  assign r_old_sq = r_old * r_old;

  assign p_sub    = full ? SumW'(p_old) : SumW'(0);
  assign r_sub    = full ? SumW'(r_old) : SumW'(0);
  assign p_sq_sub = full ? SqW'($unsigned(p_old_sq)) : SqW'(0);
  assign r_sq_sub = full ? SqW'($unsigned(r_old_sq)) : SqW'(0);

  assign psum_nxt = psum_r + SumW'(p_new) - p_sub;
  assign rsum_nxt = rsum_r + SumW'(r_new) - r_sub;
  assign psq_nxt  = psq_r + SqW'($unsigned(p_sq)) - p_sq_sub;
  assign rsq_nxt  = rsq_r + SqW'($unsigned(r_sq)) - r_sq_sub;

  always_comb begin
    wpos_nxt = wpos_r;
    if (b_fire && is_restart) begin
      wpos_nxt = '0;
    end else if (b_fire && take) begin
      wpos_nxt = wpos_r + 1'b1;
    end
  end

  szoc_ring #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk        (clk),
    .wr_en      (b_fire && take),
    .wr_addr    (wpos_r),
    .wr_pitch   ($unsigned(p_new)),
    .wr_roll    ($unsigned(r_new)),
    .rd_addr    (wpos_nxt),
    .rd_pitch_r (p_old_raw),
    .rd_roll_r  (r_old_raw)
  );

  // stillness stage logic
  logic          p_still;
  logic          r_still;
  logic          still;
  logic          cal_fin;
  logic [SB-1:0] pzero_fin;
  logic [SB-1:0] rzero_fin;

  szoc_still #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_still_pitch (
    .sum    (psum_r),
    .sq_sum (psq_r),
    .limit  (plim_r),
    .still  (p_still)
  );

  szoc_still #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_still_roll (
    .sum    (rsum_r),
    .sq_sum (rsq_r),
    .limit  (rlim_r),
    .still  (r_still)
  );

  assign c_adv     = c_valid_r && (!out_valid_r || out_ch.ready);
  assign still     = c_valid_r && c_chk_r && p_still && r_still;
  assign cal_fin   = cal_r || still;
  assign pzero_fin = still ? SB'(psum_r >>> L) : pzero_r;
  assign rzero_fin = still ? SB'(rsum_r >>> L) : rzero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      c_taken_r <= 1'b0;
      c_chk_r   <= 1'b0;
    end else if (b_fire) begin
      c_valid_r <= 1'b1;
      c_taken_r <= take;
      c_chk_r   <= chk;
    end else if (c_adv) begin
      c_valid_r <= 1'b0;
      c_chk_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r      <= '0;
      fill_r      <= '0;
      psum_r      <= '0;
      rsum_r      <= '0;
      psq_r       <= '0;
      rsq_r       <= '0;
      last_tick_r <= '0;
      cal_r       <= 1'b0;
      pzero_r     <= '0;
      rzero_r     <= '0;
    end else begin
      wpos_r <= wpos_nxt;
      if (b_fire && is_restart) begin
        fill_r      <= '0;
        psum_r      <= '0;
        rsum_r      <= '0;
        psq_r       <= '0;
        rsq_r       <= '0;
        last_tick_r <= '0;
        cal_r       <= 1'b0;
        pzero_r     <= '0;
        rzero_r     <= '0;
      end else if (b_fire && take) begin
        if (!full) begin
          fill_r <= fill_r + 1'b1;
        end
        psum_r      <= psum_nxt;
        rsum_r      <= rsum_nxt;
        psq_r       <= psq_nxt;
        rsq_r       <= rsq_nxt;
        last_tick_r <= a_tick_r;
      end else if (c_adv && still) begin
        cal_r   <= 1'b1;
        pzero_r <= pzero_fin;
        rzero_r <= rzero_fin;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv) begin
      out_taken_r <= c_taken_r;
      out_cal_r   <= cal_fin;
      out_pitch_r <= FieldW'(pzero_fin);
      out_roll_r  <= FieldW'(rzero_fin);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_taken  = out_taken_r;
  assign out_ch.is_calibrated = out_cal_r;
  assign out_ch.pitch_bias    = $signed(out_pitch_r);
  assign out_ch.roll_bias     = $signed(out_roll_r);

  // checks
  a_no_update_during_test: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r && c_chk_r |-> !b_fire)
    else $error("update stage fired while the variance test was pending");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FillW'(WINDOW))
    else $error("fill count beyond window depth");

  a_taken_only_uncalibrated: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r && c_taken_r |-> !cal_r)
    else $error("sample taken while already calibrated");

  a_offsets_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r && !(b_fire && is_restart) |=> cal_r && $stable(pzero_r) && $stable(rzero_r))
    else $error("latched offsets changed without restart");

endmodule
